[design/bcp_pkg.sv]
// Shared types, constants and register codes for the button click classifier.
package bcp_pkg;

	localparam int MAX_PAGES = 8;
	localparam int PAGE_W    = $clog2(MAX_PAGES);
	localparam int COUNT_W   = $clog2(MAX_PAGES + 1);
	localparam int CFG_W     = 16;
	localparam int CNT_REG_W = 4;
	localparam int TIME_W    = 32;
	localparam int CLICK_W   = 2;
	localparam int IDX_W     = 2;

	localparam logic [CLICK_W-1:0] CLICK_CAP = 2'd3;

	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_ADVANCE = 2'd1;
	localparam logic [1:0] ACT_DONE    = 2'd2;
	localparam logic [1:0] ACT_DROP    = 2'd3;

	localparam logic [IDX_W-1:0] REG_MIN_PRESS  = 2'd0;
	localparam logic [IDX_W-1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [IDX_W-1:0] REG_CLICK_GAP  = 2'd2;
	localparam logic [IDX_W-1:0] REG_PAGE_COUNT = 2'd3;

	localparam logic [CFG_W-1:0]     MIN_PRESS_RST  = 16'd25;
	localparam logic [CFG_W-1:0]     LONG_PRESS_RST = 16'd1200;
	localparam logic [CFG_W-1:0]     CLICK_GAP_RST  = 16'd600;
	localparam logic [CNT_REG_W-1:0] PAGE_COUNT_RST = 4'd0;

	typedef struct packed {
		logic [CFG_W-1:0]     min_press_ms;
		logic [CFG_W-1:0]     long_press_ms;
		logic [CFG_W-1:0]     click_gap_ms;
		logic [CNT_REG_W-1:0] page_count;
		logic                 cursor_clr;
	} cfg_t;

	typedef struct packed {
		logic              redraw;
		logic [PAGE_W-1:0] page;
		logic [PAGE_W-1:0] done_page;
		logic [1:0]        action;
	} res_t;

endpackage

[design/button_click_classifier_pager_unit.sv]
// Top level of the button click classifier: input stage, step logic and result stage.
//
// One button sample enters per accepted item on the s_ side: s_tdata bit 0 is the
// pressed level, bits 32:1 the millisecond timestamp. Every sample yields exactly
// one result item on the m_ side, in order: action, done page, current page cursor
// and a redraw flag.
// The sample is registered in the input stage, the step logic runs against the
// classifier state, and the result is registered in the result stage that drives
// m_. Throughput is one item per cycle while the receiver keeps m_tready high; the
// state loop closes through the combinational step logic into the state registers.
// When the receiver holds m_tready low the result register holds its item and
// the input register can still take one more sample; s_tready falls only when
// both are full.
// Configuration registers are written through cfg_wr_en / cfg_idx / cfg_wdata;
// the user must write them only while no items are in flight, unenforced by the block.
// Writing the page count sets the cursor to 0. Reset (arst_n low) empties both stages,
// clears the click state and cursor, and loads default timings and a page count of zero.
module button_click_classifier_pager_unit
	import bcp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [39:0]      s_tdata,   // pressed[0], now_ms[32:1], zero fill
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,   // action[1:0], done_page[4:2], page[7:5], redraw[8]
	input  logic             cfg_wr_en,
	input  logic [IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0] cfg_wdata
);

	cfg_t              cfg;
	res_t              res;
	logic              valid_s1;
	logic              pressed_s1;
	logic [TIME_W-1:0] now_s1;
	logic              valid_s2;
	res_t              res_s2;
	logic              adv_s2;
	logic              step;

	assign adv_s2   = !valid_s2 || m_tready;
	assign step     = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	bcp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bcp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (step),
		.pressed (pressed_s1),
		.now_ms  (now_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pressed_s1 <= s_tdata[0];
			now_s1     <= s_tdata[TIME_W:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2.redraw, res_s2.page, res_s2.done_page, res_s2.action};

	a_redraw_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.redraw |->
			(res_s2.action == ACT_ADVANCE) || (res_s2.action == ACT_DONE))
		else $error("redraw without a cursor move");

	a_advance_redraw: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_s2.action == ACT_ADVANCE) |-> res_s2.redraw)
		else $error("page advance without redraw");

	a_done_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_s2.action != ACT_DONE) |-> (res_s2.done_page == '0))
		else $error("done page set without completion request");

	a_stage1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(now_s1) && $stable(pressed_s1))
		else $error("input stage lost an item under stall");

endmodule

[design/bcp_cfg.sv]
// Configuration register file for the button click classifier.
module bcp_cfg
	import bcp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0] cfg_wdata,
	output cfg_t             cfg
);

	logic [CFG_W-1:0]     min_press_q;
	logic [CFG_W-1:0]     long_press_q;
	logic [CFG_W-1:0]     click_gap_q;
	logic [CNT_REG_W-1:0] page_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_press_q  <= MIN_PRESS_RST;
			long_press_q <= LONG_PRESS_RST;
			click_gap_q  <= CLICK_GAP_RST;
			page_count_q <= PAGE_COUNT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				REG_MIN_PRESS:  min_press_q  <= cfg_wdata;
				REG_LONG_PRESS: long_press_q <= cfg_wdata;
				REG_CLICK_GAP:  click_gap_q  <= cfg_wdata;
				REG_PAGE_COUNT: page_count_q <= cfg_wdata[CNT_REG_W-1:0];
				default:        ;
			endcase
		end
	end

	assign cfg.min_press_ms  = min_press_q;
	assign cfg.long_press_ms = long_press_q;
	assign cfg.click_gap_ms  = click_gap_q;
	assign cfg.page_count    = page_count_q;
	assign cfg.cursor_clr    = cfg_wr_en && (cfg_idx == REG_PAGE_COUNT);

endmodule

[design/bcp_core.sv]
// Click classifier state and per-sample step logic with the page cursor.
module bcp_core
	import bcp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              step,
	input  logic              pressed,
	input  logic [TIME_W-1:0] now_ms,
	output res_t              res
);

	logic                held_q;
	logic                long_seen_q;
	logic [TIME_W-1:0]   press_start_q;
	logic [CLICK_W-1:0]  clicks_q;
	logic [TIME_W-1:0]   last_release_q;
	logic [PAGE_W-1:0]   cursor_q;

	logic                new_press;
	logic                long_mid;
	logic [TIME_W-1:0]   start_mid;
	logic [TIME_W-1:0]   press_dur;
	logic                long_hit;
	logic                click_add;
	logic                long_nxt;
	logic [CLICK_W-1:0]  clicks_mid;
	logic [TIME_W-1:0]   last_nxt;
	logic [TIME_W-1:0]   gap_dur;
	logic                seq_end;
	logic [COUNT_W-1:0]  n_pages;
	logic [COUNT_W-1:0]  cur_ext;
	logic [COUNT_W-1:0]  cur_inc;
	logic [PAGE_W-1:0]   cur_wrap;
	logic [CLICK_W-1:0]  clicks_nxt;
	logic [PAGE_W-1:0]   cursor_nxt;
	logic [1:0]          action;
	logic [PAGE_W-1:0]   done_page;
	logic                redraw;

	always_comb begin
		new_press = pressed && !held_q;
		long_mid  = new_press ? 1'b0 : long_seen_q;
		start_mid = new_press ? now_ms : press_start_q;
		press_dur = now_ms - start_mid;
		long_hit  = pressed && !long_mid &&
			(press_dur >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms});
		long_nxt  = long_mid || long_hit;
		click_add = !pressed && held_q && !long_mid &&
			(press_dur >= {{(TIME_W-CFG_W){1'b0}}, cfg.min_press_ms});

		clicks_mid = clicks_q;
		last_nxt   = last_release_q;
		if (long_hit) begin
			clicks_mid = '0;
		end
		if (click_add) begin
			if (clicks_q != CLICK_CAP) begin
				clicks_mid = clicks_q + 1'b1;
			end
			last_nxt = now_ms;
		end

		gap_dur = now_ms - last_nxt;
		seq_end = !pressed && (clicks_mid != '0) &&
			(gap_dur > {{(TIME_W-CFG_W){1'b0}}, cfg.click_gap_ms});

		n_pages  = (cfg.page_count > COUNT_W'(MAX_PAGES)) ? COUNT_W'(MAX_PAGES)
			: cfg.page_count[COUNT_W-1:0];
		cur_ext  = {{(COUNT_W-PAGE_W){1'b0}}, cursor_q};
		cur_inc  = cur_ext + 1'b1;
		cur_wrap = (cur_inc >= n_pages) ? '0 : cur_inc[PAGE_W-1:0];

		clicks_nxt = clicks_mid;
		cursor_nxt = cursor_q;
		action     = ACT_NONE;
		done_page  = '0;
		redraw     = 1'b0;
		if (seq_end) begin
			clicks_nxt = '0;
			case (clicks_mid)
				2'd1: begin
					if (n_pages < COUNT_W'(2)) begin
						action = ACT_DROP;
					end else begin
						cursor_nxt = cur_wrap;
						action     = ACT_ADVANCE;
						redraw     = 1'b1;
					end
				end
				2'd2: begin
					if ((n_pages == '0) || (cur_ext >= n_pages)) begin
						action = ACT_DROP;
					end else begin
						action    = ACT_DONE;
						done_page = cursor_q;
						if (n_pages > COUNT_W'(1)) begin
							cursor_nxt = cur_wrap;
							redraw     = 1'b1;
						end
					end
				end
				default: action = ACT_DROP;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q         <= 1'b0;
			long_seen_q    <= 1'b0;
			press_start_q  <= '0;
			clicks_q       <= '0;
			last_release_q <= '0;
			cursor_q       <= '0;
		end else if (cfg.cursor_clr) begin
			cursor_q <= '0;
		end else if (step) begin
			held_q         <= pressed;
			long_seen_q    <= long_nxt;
			press_start_q  <= start_mid;
			clicks_q       <= clicks_nxt;
			last_release_q <= last_nxt;
			cursor_q       <= cursor_nxt;
		end
	end

	assign res.action    = action;
	assign res.done_page = done_page;
	assign res.page      = cursor_nxt;
	assign res.redraw    = redraw;

endmodule
